// ===== rtl/core/gfcm_pkg.sv =====
// Shared types, constants and a helper function for the GA fitness convergence monitor.
// Has no dependencies; every other module of the block imports it.
`default_nettype none

package gfcm_pkg;

  // Sizing of the monitored population and of one chromosome.
  localparam int MAX_POPULATION = 64;
  localparam int GENE_BITS      = 64;

  localparam int GENE_W   = 64;                      // chromosome and target field width
  localparam int LEN_W    = 7;                       // chromosome_length register width
  localparam int FIT_W    = 7;                       // fitness field width
  localparam int POS_W    = 6;                       // item index width
  localparam int STALL_W  = 8;
  localparam int GEN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [GENE_W-1:0]  TARGET_RESET = 64'hf00000000000000f;
  localparam logic [LEN_W-1:0]   LENGTH_RESET = 7'd64;
  localparam logic [STALL_W-1:0] STALL_RESET  = 8'd30;
  localparam logic [POS_W-1:0]   POS_LAST     = POS_W'(MAX_POPULATION - 1);
  localparam logic [STALL_W-1:0] STALL_MAX    = '1;
  localparam logic [GEN_W-1:0]   GEN_MAX      = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PATTERN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMOSOME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT       = 2'd2;

  typedef enum logic [1:0] {
    STATUS_CONTINUE = 2'd0,
    STATUS_TARGET   = 2'd1,
    STATUS_STALLED  = 2'd2
  } stop_status_t;

  // Per-generation summary that travels from the tracker to the result register.
  typedef struct packed {
    logic                gen_done;
    logic [FIT_W-1:0]    best_fitness;
    logic [POS_W-1:0]    best_index;
    logic [STALL_W-1:0]  stall_count;
    logic [GEN_W-1:0]    gen_number;
    stop_status_t        stop_status;
  } gen_summary_t;

  // Number of bits actually compared: the length register clipped to the gene count.
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(GENE_BITS)) begin
      return LEN_W'(GENE_BITS);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gfcm_fitness.sv =====
// Masked match count of one chromosome against the target pattern.
// Depends on gfcm_pkg.
`default_nettype none

module gfcm_fitness
  import gfcm_pkg::*;
(
  input  wire logic [GENE_W-1:0] chromosome,
  input  wire logic [GENE_W-1:0] target,
  input  wire logic [LEN_W-1:0]  length_cfg,
  output logic      [FIT_W-1:0]  fitness
);

  logic [LEN_W-1:0]  len_eff;
  logic [GENE_W-1:0] same;

  // Popcount as a shallow tree: eight byte counts, then three levels of pairwise sums.
  logic [3:0]        grp_cnt  [8];
  logic [4:0]        pair_cnt [4];
  logic [5:0]        quad_cnt [2];

  assign len_eff = eff_length(length_cfg);

  always_comb begin
    for (int i = 0; i < GENE_W; i++) begin
      same[i] = (chromosome[i] == target[i]) && (LEN_W'(i) < len_eff);
    end
  end

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_cnt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_cnt[g] = grp_cnt[g] + 4'(same[8*g+b]);
      end
    end
    for (int p = 0; p < 4; p++) begin
      pair_cnt[p] = 5'(grp_cnt[2*p]) + 5'(grp_cnt[2*p+1]);
    end
    for (int q = 0; q < 2; q++) begin
      quad_cnt[q] = 6'(pair_cnt[2*q]) + 6'(pair_cnt[2*q+1]);
    end
    fitness = FIT_W'(quad_cnt[0]) + FIT_W'(quad_cnt[1]);
  end

endmodule

`default_nettype wire

// ===== rtl/core/gfcm_tracker.sv =====
// Running best per generation, stall counting and stop decision.
// Depends on gfcm_pkg.
`default_nettype none

module gfcm_tracker
  import gfcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire logic [FIT_W-1:0]   fitness,
  input  wire logic               last_item,
  input  wire logic [LEN_W-1:0]   length_cfg,
  input  wire logic [STALL_W-1:0] stall_limit,
  output gen_summary_t            summary
);

  logic [FIT_W-1:0]   run_best_r,  run_best_nxt;
  logic [POS_W-1:0]   run_pos_r,   run_pos_nxt;
  logic [POS_W-1:0]   item_pos_r,  item_pos_nxt;
  logic [FIT_W-1:0]   prev_best_r, prev_best_nxt;
  logic [STALL_W-1:0] stall_r,     stall_nxt;
  logic               first_gen_r, first_gen_nxt;
  logic [GEN_W-1:0]   gen_r,       gen_nxt;

  logic               take;
  logic [FIT_W-1:0]   best_cur;
  logic [POS_W-1:0]   pos_cur;
  logic [LEN_W-1:0]   len_eff;

  assign len_eff  = eff_length(length_cfg);
  // The first item of a generation always seeds the best; later ones only on a strict win.
  assign take     = (item_pos_r == '0) || (fitness > run_best_r);
  assign best_cur = take ? fitness : run_best_r;
  assign pos_cur  = take ? item_pos_r : run_pos_r;

  always_comb begin
    run_best_nxt  = best_cur;
    run_pos_nxt   = pos_cur;
    item_pos_nxt  = (item_pos_r == POS_LAST) ? item_pos_r : item_pos_r + 1'b1;
    prev_best_nxt = prev_best_r;
    stall_nxt     = stall_r;
    first_gen_nxt = first_gen_r;
    gen_nxt       = gen_r;
    summary       = '0;

    if (last_item) begin
      if (first_gen_r) begin
        prev_best_nxt = best_cur;
        first_gen_nxt = 1'b0;
      end else if (best_cur == prev_best_r) begin
        if (stall_r != STALL_MAX) begin
          stall_nxt = stall_r + 1'b1;
        end
      end else begin
        prev_best_nxt = best_cur;
        stall_nxt     = '0;
      end

      summary.gen_done     = 1'b1;
      summary.best_fitness = best_cur;
      summary.best_index   = pos_cur;
      summary.stall_count  = stall_nxt;
      summary.gen_number   = gen_r;
      if (LEN_W'(prev_best_nxt) == len_eff) begin
        summary.stop_status = STATUS_TARGET;
      end else if (stall_nxt >= stall_limit) begin
        summary.stop_status = STATUS_STALLED;
      end else begin
        summary.stop_status = STATUS_CONTINUE;
      end

      gen_nxt      = (gen_r == GEN_MAX) ? gen_r : gen_r + 1'b1;
      item_pos_nxt = '0;
      run_best_nxt = '0;
      run_pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_best_r  <= '0;
      run_pos_r   <= '0;
      item_pos_r  <= '0;
      prev_best_r <= '0;
      stall_r     <= '0;
      first_gen_r <= 1'b1;
      gen_r       <= '0;
    end else if (advance) begin
      run_best_r  <= run_best_nxt;
      run_pos_r   <= run_pos_nxt;
      item_pos_r  <= item_pos_nxt;
      prev_best_r <= prev_best_nxt;
      stall_r     <= stall_nxt;
      first_gen_r <= first_gen_nxt;
      gen_r       <= gen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ga_fitness_convergence_monitor_unit.sv =====
// Top level of the GA fitness convergence monitor: input register, fitness and
// tracker logic, result register and configuration registers. Depends on gfcm_pkg,
// gfcm_fitness and gfcm_tracker.
`default_nettype none

// The monitor takes one chromosome item per clock while out_ready keeps the result
// register draining, and returns exactly one result item for each. An accepted item
// lands in an input register, where its masked match count (fitness) is formed by a
// 64-bit popcount; when the output register is empty or being drained, the generation
// tracker updates its running best, stall counter and generation counter, and the
// result is loaded into the output register. The popcount plus compare path between
// the two registers is combinational. The input side keeps taking items while a
// finished result waits, until both the input register and the output register are
// full. Items with last_in_generation set also carry the generation summary (best
// fitness, index of its first occurrence, stall count, generation number and stop
// status); on other items those fields read zero. Configuration registers (target
// pattern, chromosome length, stall limit) are written through a simple write port
// and should only be changed while no item is in flight; writes to an unknown index
// are ignored. The block never halts on a stop status: it keeps reporting for every
// generation that follows.
module ga_fitness_convergence_monitor_unit
  import gfcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [GENE_W-1:0]     in_chromosome_bits,
  input  wire logic                  in_last_in_generation,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FIT_W-1:0]           out_fitness_value,
  output logic                       out_generation_done,
  output logic [FIT_W-1:0]           out_best_fitness,
  output logic [POS_W-1:0]           out_best_index,
  output logic [STALL_W-1:0]         out_stall_count,
  output logic [GEN_W-1:0]           out_generation_number,
  output logic [1:0]                 out_stop_status,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [GENE_W-1:0]  target_r;
  logic [LEN_W-1:0]   length_r;
  logic [STALL_W-1:0] stall_limit_r;

  // Input register stage.
  logic               s1_valid_r;
  logic [GENE_W-1:0]  s1_bits_r;
  logic               s1_last_r;

  // Result register stage.
  logic               out_valid_r;
  logic [FIT_W-1:0]   out_fit_r;
  gen_summary_t       out_sum_r;

  logic               in_fire;
  logic               s1_adv;
  logic [FIT_W-1:0]   fitness;
  gen_summary_t       summary;

  // The input register moves on whenever the result register is empty or being drained.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= TARGET_RESET;
      length_r      <= LENGTH_RESET;
      stall_limit_r <= STALL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_PATTERN:    target_r      <= cfg_wdata;
        CFG_CHROMOSOME_LENGTH: length_r      <= cfg_wdata[LEN_W-1:0];
        CFG_STALL_LIMIT:       stall_limit_r <= cfg_wdata[STALL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bits_r <= in_chromosome_bits;
      s1_last_r <= in_last_in_generation;
    end
  end

  gfcm_fitness u_fitness (
    .chromosome (s1_bits_r),
    .target     (target_r),
    .length_cfg (length_r),
    .fitness    (fitness)
  );

  gfcm_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_adv),
    .fitness     (fitness),
    .last_item   (s1_last_r),
    .length_cfg  (length_r),
    .stall_limit (stall_limit_r),
    .summary     (summary)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_fit_r <= fitness;
      out_sum_r <= summary;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_fitness_value     = out_fit_r;
  assign out_generation_done   = out_sum_r.gen_done;
  assign out_best_fitness      = out_sum_r.best_fitness;
  assign out_best_index        = out_sum_r.best_index;
  assign out_stall_count       = out_sum_r.stall_count;
  assign out_generation_number = out_sum_r.gen_number;
  assign out_stop_status       = out_sum_r.stop_status;

  // An accepted item always occupies the input register in the next cycle.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item did not reach the input register");

  // A waiting result must block the input register from overwriting it.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_adv)
    else $error("result register overwritten while stalled");

  // The generation best includes the last item, so it cannot be below its fitness.
  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sum_r.gen_done) |-> (out_sum_r.best_fitness >= out_fit_r))
    else $error("generation best below fitness of its last item");

  // The best fitness and stop status stay zero on items that do not close a generation.
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_sum_r.gen_done) |->
      (out_sum_r.best_fitness == '0 && out_sum_r.stop_status == STATUS_CONTINUE))
    else $error("summary fields set on a non-final item");

endmodule

`default_nettype wire
